@@ sv/iterative_quicksort_engine_macros.svh @@
// Assertion macros shared by the checker.
`ifndef ITERATIVE_QUICKSORT_ENGINE_MACROS_SVH
`define ITERATIVE_QUICKSORT_ENGINE_MACROS_SVH
// Assert an implication on every clock edge outside reset.
`define IQS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert that the consequent holds in the cycle after the antecedent.
`define IQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ sv/iqs_pkg.sv @@
package iqs_pkg;
	localparam int unsigned DEPTH = 1024;
	localparam int unsigned STACK_DEPTH = 1024;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned SW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned WW = 32;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_SORT  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// Compare unit result: a > b under the selected ordering.
	function automatic logic word_greater(input logic [WW-1:0] a, input logic [WW-1:0] b,
		input logic sgn);
		logic [WW-1:0] x;
		logic [WW-1:0] y;
		x = a ^ {sgn, {(WW-1){1'b0}}};
		y = b ^ {sgn, {(WW-1){1'b0}}};
		return x > y;
	endfunction
endpackage

@@ sv/iterative_quicksort_engine.sv @@
// Iterative quicksort engine for up to 1024 32-bit words.
// Command channel: start with op, word_in and read_index is taken at a clock
// edge where start is high and busy is low. Each command yields exactly one
// result word (word_out, word_count, status) shown for one cycle with done
// high; the receiver cannot stall it, so no result is ever held back.
// Push and clear go from idle straight to S_DONE; an in-range read passes
// S_RDWT first for its one word-store read. Sort runs a sequencer around one
// shared compare unit: each partition step passes S_LOOP for the loop test,
// S_RL and S_RR to read two words from the single-read-port store and S_CMP
// to compare them; a swap writes the right slot in S_CMP and adds S_SW2 to
// write back the second word. Each popped range adds S_POP and S_POPW for the
// pop, the final loop test and S_PUSH1 and S_PUSH2 for the two pushes. busy
// stays high from the accepting edge until the result word.
// Configuration channel: cfg_valid/cfg_ready/cfg_data write compare_signed,
// 1 for two's complement compares, 0 for unsigned. cfg_ready is always high.
// Reset (arst_n low) empties the store, resets compare_signed to 1 and the
// sequencer to idle. The word store and range stack have no clearing pass;
// only loaded entries are ever read.
module iterative_quicksort_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                op,
	input  logic [31:0]               word_in,
	input  logic [9:0]                read_index,
	output logic                      done,
	output logic [31:0]               word_out,
	output logic [10:0]               word_count,
	output logic [1:0]                status,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_data
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RDWT  = 4'd1;
	localparam logic [3:0] S_POP   = 4'd2;
	localparam logic [3:0] S_POPW  = 4'd3;
	localparam logic [3:0] S_RL    = 4'd4;
	localparam logic [3:0] S_RR    = 4'd5;
	localparam logic [3:0] S_CMP   = 4'd6;
	localparam logic [3:0] S_SW2   = 4'd7;
	localparam logic [3:0] S_PUSH1 = 4'd8;
	localparam logic [3:0] S_PUSH2 = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;
	localparam logic [3:0] S_LOOP  = 4'd11;

	logic [3:0] state_q;
	logic [iqs_pkg::CW-1:0] count_q;
	logic sgn_q;
	logic [iqs_pkg::AW-1:0] lo_q, hi_q, lp_q, rp_q;
	logic move_left_q;
	logic [iqs_pkg::WW-1:0] wl_q;
	logic [iqs_pkg::SW:0] top_q;
	logic done_q;
	logic [31:0] out_q;
	logic [1:0] status_q;

	// Word store port.
	logic st_we;
	logic [iqs_pkg::AW-1:0] st_waddr, st_raddr;
	logic [iqs_pkg::WW-1:0] st_wdata, st_rdata;
	// Range stack port.
	logic sk_we;
	logic [iqs_pkg::SW-1:0] sk_waddr, sk_raddr;
	logic [2*iqs_pkg::AW-1:0] sk_wdata, sk_rdata;

	iqs_ram #(.WIDTH(iqs_pkg::WW), .DEPTH(iqs_pkg::DEPTH)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);
	iqs_ram #(.WIDTH(2*iqs_pkg::AW), .DEPTH(iqs_pkg::STACK_DEPTH)) u_stack (
		.clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
		.raddr(sk_raddr), .rdata(sk_rdata)
	);

	logic gt;
	logic [iqs_pkg::AW-1:0] lp_n, rp_n;
	logic ml_n;
	assign gt = iqs_pkg::word_greater(wl_q, st_rdata, sgn_q);
	assign ml_n = gt ? !move_left_q : move_left_q;
	assign lp_n = ml_n ? lp_q + 1'b1 : lp_q;
	assign rp_n = ml_n ? rp_q : rp_q - 1'b1;

	// Subrange tests; pointers are compared one bit wider to avoid wrap.
	logic push_left, push_right;
	assign push_left  = ({1'b0, lo_q} + 1'b1) < {1'b0, lp_q};
	assign push_right = ({1'b0, lp_q} + 1'b1) < {1'b0, hi_q};
	logic stack_room;
	assign stack_room = top_q < (iqs_pkg::SW+1)'(iqs_pkg::STACK_DEPTH);

	assign busy = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign word_out = out_q;
	assign word_count = count_q;
	assign status = status_q;

	always_comb begin
		st_we = 1'b0;
		st_waddr = count_q[iqs_pkg::AW-1:0];
		st_wdata = word_in;
		st_raddr = read_index[iqs_pkg::AW-1:0];
		sk_we = 1'b0;
		sk_waddr = top_q[iqs_pkg::SW-1:0];
		sk_wdata = {lo_q, hi_q};
		sk_raddr = top_q[iqs_pkg::SW-1:0] - 1'b1;
		unique case (state_q)
			S_IDLE: begin
				st_we = start && op == iqs_pkg::OP_PUSH
					&& count_q < iqs_pkg::CW'(iqs_pkg::DEPTH);
				sk_waddr = '0;
				sk_wdata = {{iqs_pkg::AW{1'b0}}, iqs_pkg::AW'(count_q - 1'b1)};
				sk_we = start && op == iqs_pkg::OP_SORT && count_q >= iqs_pkg::CW'(2);
			end
			S_RL: st_raddr = lp_q;
			S_RR: st_raddr = rp_q;
			S_CMP: begin
				// Swap: the right slot takes the left word now.
				st_we = gt;
				st_waddr = rp_q;
				st_wdata = wl_q;
			end
			S_SW2: begin
				st_we = 1'b1;
				st_waddr = lp_q;
				st_wdata = wl_q;
			end
			S_PUSH1: begin
				sk_we = push_left && stack_room;
				sk_wdata = {lo_q, lp_q - 1'b1};
			end
			S_PUSH2: begin
				sk_we = push_right && stack_room;
				sk_wdata = {lp_q + 1'b1, hi_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			sgn_q <= 1'b1;
			top_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				sgn_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						out_q <= '0;
						status_q <= iqs_pkg::ST_OK;
						case (op)
							iqs_pkg::OP_PUSH: begin
								if (count_q < iqs_pkg::CW'(iqs_pkg::DEPTH)) begin
									count_q <= count_q + 1'b1;
								end else begin
									status_q <= iqs_pkg::ST_FULL;
								end
								state_q <= S_DONE;
							end
							iqs_pkg::OP_SORT: begin
								if (count_q >= iqs_pkg::CW'(2)) begin
									top_q <= (iqs_pkg::SW+1)'(1);
									state_q <= S_POP;
								end else begin
									state_q <= S_DONE;
								end
							end
							iqs_pkg::OP_READ: begin
								if ({1'b0, read_index} < count_q) begin
									state_q <= S_RDWT;
								end else begin
									status_q <= iqs_pkg::ST_RANGE;
									state_q <= S_DONE;
								end
							end
							default: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RDWT: begin
					out_q <= st_rdata;
					state_q <= S_DONE;
				end
				S_POP: begin
					if (top_q == '0) begin
						state_q <= S_DONE;
					end else begin
						top_q <= top_q - 1'b1;
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					lo_q <= sk_rdata[2*iqs_pkg::AW-1:iqs_pkg::AW];
					hi_q <= sk_rdata[iqs_pkg::AW-1:0];
					lp_q <= sk_rdata[2*iqs_pkg::AW-1:iqs_pkg::AW];
					rp_q <= sk_rdata[iqs_pkg::AW-1:0];
					move_left_q <= 1'b0;
					state_q <= S_LOOP;
				end
				S_LOOP: begin
					state_q <= (rp_q > lp_q) ? S_RL : S_PUSH1;
				end
				S_RL: state_q <= S_RR;
				S_RR: begin
					wl_q <= st_rdata;
					state_q <= S_CMP;
				end
				S_CMP: begin
					move_left_q <= ml_n;
					if (gt) begin
						// Left slot takes the right word next cycle.
						wl_q <= st_rdata;
						state_q <= S_SW2;
					end else begin
						lp_q <= lp_n;
						rp_q <= rp_n;
						state_q <= S_LOOP;
					end
				end
				S_SW2: begin
					if (move_left_q) begin
						lp_q <= lp_q + 1'b1;
					end else begin
						rp_q <= rp_q - 1'b1;
					end
					state_q <= S_LOOP;
				end
				S_PUSH1: begin
					if (push_left && stack_room) begin
						top_q <= top_q + 1'b1;
					end
					state_q <= S_PUSH2;
				end
				S_PUSH2: begin
					if (push_right && stack_room) begin
						top_q <= top_q + 1'b1;
					end
					state_q <= S_POP;
				end
				S_DONE: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ sv/iqs_ram.sv @@
module iqs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sv/iqs_checker.sv @@
`include "iterative_quicksort_engine_macros.svh"
module iqs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [10:0] word_count,
	input logic [1:0]  status,
	input logic [31:0] word_out
);
	logic err_word;
	assign err_word = status != iqs_pkg::ST_OK;

	`IQS_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "command not taken")
	`IQS_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy, "busy during result word")
	`IQS_ASSERT_IMP(a_count_max, clk, arst_n, done, word_count <= 11'(iqs_pkg::DEPTH), "count overflow")
	`IQS_ASSERT_IMP(a_err_zero, clk, arst_n, done && err_word, word_out == '0, "error word nonzero")
endmodule

bind iterative_quicksort_engine iqs_checker u_iqs_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.word_count(word_count), .status(status), .word_out(word_out)
);

@@ test/tb_iterative_quicksort_engine.sv @@
module tb_iterative_quicksort_engine;
	// One command word as it goes to the engine. A set drain flag makes the
	// driver hold this word back until every outstanding result has come in.
	typedef struct {
		logic [1:0]  op;
		logic [31:0] word;
		logic [9:0]  idx;
		bit          drain;
	} command_t;

	// One result word as the engine shows it while done is high.
	typedef struct {
		logic [31:0] word;
		logic [10:0] count;
		logic [1:0]  status;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = iqs_pkg::OP_PUSH;
	logic [31:0] word_in = '0;
	logic [9:0]  read_index = '0;
	logic        done;
	logic [31:0] word_out;
	logic [10:0] word_count;
	logic [1:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;

	iterative_quicksort_engine dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.word_in(word_in), .read_index(read_index), .done(done),
		.word_out(word_out), .word_count(word_count), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Commands waiting to be driven, compare_signed values waiting to be
	// written, and the replies the engine still owes us, oldest first.
	command_t    pending_cmds[$];
	bit          pending_modes[$];
	reply_t      owed_replies[$];
	int unsigned mode_writes = 0;
	int unsigned errors = 0;

	// Shadow copy of the engine: the store, its fill level and the ordering.
	logic [31:0] shadow_store[iqs_pkg::DEPTH];
	int unsigned shadow_count = 0;
	bit          signed_order = 1'b1;

	function automatic bit ranks_above(logic [31:0] a, logic [31:0] b);
		if (signed_order)
			return $signed(a) > $signed(b);
		return a > b;
	endfunction

	// Exchange-partition quicksort over the shadow store. Ranges are kept on
	// an explicit LIFO; the left subrange goes on first, so the right one is
	// taken next, exactly in the order the engine works through them.
	function automatic void quicksort_shadow();
		int unsigned lo_stack[$];
		int unsigned hi_stack[$];
		int unsigned lo, hi, lp, rp;
		bit          move_left;
		logic [31:0] t;
		if (shadow_count < 2)
			return;
		lo_stack.push_back(0);
		hi_stack.push_back(shadow_count - 1);
		while (lo_stack.size() != 0) begin
			lo = lo_stack.pop_back();
			hi = hi_stack.pop_back();
			lp = lo;
			rp = hi;
			move_left = 1'b0;
			while (rp > lp) begin
				if (ranks_above(shadow_store[lp], shadow_store[rp])) begin
					t = shadow_store[rp];
					shadow_store[rp] = shadow_store[lp];
					shadow_store[lp] = t;
					move_left = !move_left;
				end
				if (move_left)
					lp++;
				else
					rp--;
			end
			if (lo + 1 < lp) begin
				lo_stack.push_back(lo);
				hi_stack.push_back(lp - 1);
			end
			if (lp + 1 < hi) begin
				lo_stack.push_back(lp + 1);
				hi_stack.push_back(hi);
			end
		end
	endfunction

	// Applies one accepted command to the shadow and returns the reply it owes.
	function automatic reply_t apply_command(command_t c);
		reply_t r;
		r.word = '0;
		r.status = iqs_pkg::ST_OK;
		case (c.op)
			iqs_pkg::OP_PUSH: begin
				if (shadow_count < iqs_pkg::DEPTH) begin
					shadow_store[shadow_count] = c.word;
					shadow_count++;
				end else begin
					r.status = iqs_pkg::ST_FULL;
				end
			end
			iqs_pkg::OP_SORT: quicksort_shadow();
			iqs_pkg::OP_READ: begin
				if (c.idx < shadow_count)
					r.word = shadow_store[c.idx];
				else
					r.status = iqs_pkg::ST_RANGE;
			end
			default: shadow_count = 0;
		endcase
		r.count = shadow_count[10:0];
		return r;
	endfunction

	// Reset is held low from time zero, released once and never asserted again.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver. The command on the ports is taken at an edge where start is
	// high and busy is low; the shadow is updated at that same edge. The
	// sender works in bursts separated by random gaps, and now and then a
	// long stretch without gaps. Each branch gives start one assignment only.
	command_t    on_port;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				owed_replies.push_back(apply_command(on_port));
			if (!start || !busy) begin
				if (gap_left != 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_cmds.size() != 0 &&
						!(pending_cmds[0].drain && (owed_replies.size() != 0 || busy))) begin
					on_port = pending_cmds.pop_front();
					op <= on_port.op;
					word_in <= on_port.word;
					read_index <= on_port.idx;
					start <= 1'b1;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
							: $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					start <= 1'b0;
				end
			end
			// compare_signed writes are only queued while the engine is idle.
			if (cfg_valid && cfg_ready) begin
				signed_order = cfg_data;
				mode_writes++;
				cfg_valid <= 1'b0;
			end else if (!cfg_valid && pending_modes.size() != 0) begin
				cfg_data <= pending_modes.pop_front();
				cfg_valid <= 1'b1;
			end
		end
	end

	// Monitor. Every strobed result is matched against the oldest owed reply.
	reply_t owed;

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (owed_replies.size() == 0) begin
				$display("%0t: result with nothing owed: word_out %h count %0d status %0d",
					$time, word_out, word_count, status);
				errors++;
			end else begin
				owed = owed_replies.pop_front();
				if (word_out !== owed.word) begin
					$display("%0t: word_out expected %h actual %h", $time, owed.word, word_out);
					errors++;
				end
				if (word_count !== owed.count) begin
					$display("%0t: word_count expected %0d actual %0d",
						$time, owed.count, word_count);
					errors++;
				end
				if (status !== owed.status) begin
					$display("%0t: status expected %0d actual %0d", $time, owed.status, status);
					errors++;
				end
			end
		end
	end

	// Stimulus generation keeps its own running fill level so that reads
	// land mostly inside the loaded words.
	int unsigned gen_count = 0;
	int unsigned queued = 0;

	task automatic send(logic [1:0] o, logic [31:0] w, logic [9:0] i, bit d = 1'b0);
		command_t c;
		c.op = o;
		c.word = w;
		c.idx = i;
		c.drain = d;
		pending_cmds.push_back(c);
		queued++;
		case (o)
			iqs_pkg::OP_PUSH:  if (gen_count < iqs_pkg::DEPTH) gen_count++;
			iqs_pkg::OP_CLEAR: gen_count = 0;
			default: ;
		endcase
	endtask

	// Words are drawn from a mix that favors sign boundaries and repeats.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 3);
			4: return {$urandom_range(0, 1) ? 4'hf : 4'h0, 28'($urandom_range(0, 7))};
			default: return $urandom;
		endcase
	endfunction

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || start || busy || owed_replies.size() != 0);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_mode(bit v);
		int unsigned before_cnt;
		before_cnt = mode_writes;
		pending_modes.push_back(v);
		do
			@(negedge clk);
		while (mode_writes == before_cnt);
	endtask

	// Well-formed sequences (load, sort, read back) dominate; a minority of
	// commands are fully random noise.
	task automatic random_phase(int unsigned n);
		int unsigned stop_at;
		int unsigned k;
		stop_at = queued + n;
		while (queued < stop_at) begin
			k = $urandom_range(0, 99);
			if (k < 35) begin
				repeat ($urandom_range(1, 12))
					send(iqs_pkg::OP_PUSH, pick_word(), 10'($urandom));
			end else if (k < 50) begin
				send(iqs_pkg::OP_SORT, $urandom, 10'($urandom));
			end else if (k < 75) begin
				repeat ($urandom_range(1, 6))
					send(iqs_pkg::OP_READ, $urandom,
						(gen_count != 0 && $urandom_range(0, 9) != 0)
						? 10'($urandom_range(0, gen_count - 1)) : 10'($urandom));
			end else if (k < 80 || gen_count > 60) begin
				send(iqs_pkg::OP_CLEAR, $urandom, 10'($urandom));
			end else begin
				send(2'($urandom), $urandom, 10'($urandom), $urandom_range(0, 15) == 0);
			end
		end
	endtask

	initial begin
		@(posedge arst_n);
		// Directed: sign boundaries, the empty and one-word sort, reads past
		// the end and both ends of the index field, and a clear.
		send(iqs_pkg::OP_SORT, 32'h0, 10'h0);
		send(iqs_pkg::OP_READ, 32'h0, 10'h0);
		send(iqs_pkg::OP_PUSH, 32'h7fff_ffff, 10'h3ff);
		send(iqs_pkg::OP_SORT, 32'hffff_ffff, 10'h0);
		send(iqs_pkg::OP_PUSH, 32'hffff_ffff, 10'h0);
		send(iqs_pkg::OP_PUSH, 32'h8000_0000, 10'h0);
		send(iqs_pkg::OP_PUSH, 32'h0000_0000, 10'h0);
		send(iqs_pkg::OP_PUSH, 32'h0000_0001, 10'h0);
		send(iqs_pkg::OP_PUSH, 32'hffff_ffff, 10'h0);
		send(iqs_pkg::OP_SORT, 32'h0, 10'h0);
		for (int i = 0; i < 6; i++)
			send(iqs_pkg::OP_READ, 32'h0, 10'(i));
		send(iqs_pkg::OP_READ, 32'h0, 10'h3ff);
		send(iqs_pkg::OP_CLEAR, 32'h0, 10'h0);
		send(iqs_pkg::OP_READ, 32'h0, 10'h0, 1'b1);
		wait_idle();

		// Unsigned ordering over the same kind of data.
		write_mode(1'b0);
		send(iqs_pkg::OP_PUSH, 32'h8000_0000, 10'h0);
		send(iqs_pkg::OP_PUSH, 32'h7fff_ffff, 10'h0);
		send(iqs_pkg::OP_PUSH, 32'hffff_ffff, 10'h0);
		send(iqs_pkg::OP_SORT, 32'h0, 10'h0);
		send(iqs_pkg::OP_READ, 32'h0, 10'h0);
		send(iqs_pkg::OP_READ, 32'h0, 10'h2);
		random_phase(120);
		wait_idle();

		// One full load: fill to the top, overflow, sort, and read both ends.
		write_mode(1'b1);
		send(iqs_pkg::OP_CLEAR, 32'h0, 10'h0);
		for (int i = 0; i < iqs_pkg::DEPTH; i++)
			send(iqs_pkg::OP_PUSH, pick_word(), 10'($urandom));
		send(iqs_pkg::OP_PUSH, 32'hdead_beef, 10'h0);
		send(iqs_pkg::OP_SORT, 32'h0, 10'h0);
		send(iqs_pkg::OP_READ, 32'h0, 10'h0);
		send(iqs_pkg::OP_READ, 32'h0, 10'h3ff);
		send(iqs_pkg::OP_READ, 32'h0, 10'($urandom));
		send(iqs_pkg::OP_CLEAR, 32'h0, 10'h0);
		wait_idle();

		// Remaining random phases alternate the ordering.
		write_mode(1'b0);
		random_phase(120);
		wait_idle();
		write_mode(1'b1);
		random_phase(120);
		wait_idle();
		write_mode(1'b0);
		random_phase(100);
		wait_idle();
		write_mode(1'b1);
		random_phase(60);

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog, well beyond the slowest legal run, which is a sort of a full
	// store of repeated words.
	initial begin
		#200_000_000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+sv
sv/iqs_pkg.sv
sv/iqs_ram.sv
sv/iterative_quicksort_engine.sv
sv/iqs_checker.sv
test/tb_iterative_quicksort_engine.sv
